@@ rtl/utf8_decoder_with_replacement_defines.svh @@
// Assertion macros used by the decoder back end.
`ifndef UTF8_DECODER_WITH_REPLACEMENT_DEFINES_SVH
`define UTF8_DECODER_WITH_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UTF8D_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define UTF8D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/utf8d_pkg.sv @@
package utf8d_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned REP_CNT_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] REPL_CHAR   = 21'h00003F;
  localparam logic [CP_W-1:0] MAX_CP      = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;

  localparam logic [1:0] CLASS_2B = 2'd0;
  localparam logic [1:0] CLASS_3B = 2'd1;
  localparam logic [1:0] CLASS_4B = 2'd2;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_CHAR,
    TAIL_END
  } tail_t;

  // One decoded byte's worth of output: a run of '?' then an optional tail.
  typedef struct packed {
    logic [REP_CNT_W-1:0] rep_cnt;
    tail_t                tail;
    logic [CP_W-1:0]      cp;
  } cmd_t;

  // Smallest legal scalar for a sequence class (overlong check).
  function automatic logic [CP_W-1:0] class_floor(input logic [1:0] cls);
    logic [CP_W-1:0] v;
    unique case (cls)
      CLASS_2B: v = 21'h000080;
      CLASS_3B: v = 21'h000800;
      default:  v = 21'h010000;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/utf8d_front.sv @@
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic [7:0]  byte_value,
  output logic        byte_stall,
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  logic [CP_W-1:0] acc;
  logic [2:0]      expected;
  logic [2:0]      taken;
  logic [1:0]      min_class;

  logic [CP_W-1:0] acc_next;
  logic [2:0]      expected_next;
  logic [2:0]      taken_next;
  logic [1:0]      min_class_next;

  logic            accept;
  logic            pending;
  logic            is_cont;
  logic [CP_W-1:0] acc_ext;
  logic [2:0]      taken_inc;
  logic            bad;

  assign accept     = byte_valid && !q_full;
  assign byte_stall = q_full;

  assign pending   = (expected != 3'd0);
  assign is_cont   = (byte_value[7:6] == 2'b10);
  assign acc_ext   = {acc[CP_W-7:0], byte_value[5:0]};
  assign taken_inc = taken + 3'd1;
  assign bad       = (acc_ext < class_floor(min_class)) || (acc_ext > MAX_CP) ||
                     ((acc_ext >= SURR_LO) && (acc_ext <= SURR_HI));

  always_comb begin
    acc_next       = acc;
    expected_next  = expected;
    taken_next     = taken;
    min_class_next = min_class;
    cmd.rep_cnt    = '0;
    cmd.tail       = TAIL_NONE;
    cmd.cp         = acc_ext;
    if (pending && is_cont) begin
      if (taken_inc >= expected) begin
        // sequence complete: one scalar, or one '?' per byte taken
        if (bad) begin
          cmd.rep_cnt = taken_inc;
        end else begin
          cmd.tail = TAIL_CHAR;
        end
        acc_next       = '0;
        expected_next  = '0;
        taken_next     = '0;
        min_class_next = '0;
      end else begin
        acc_next   = acc_ext;
        taken_next = taken_inc;
      end
    end else begin
      // flush a broken sequence, then treat the byte as a lead
      cmd.rep_cnt    = pending ? taken : 3'd0;
      acc_next       = '0;
      expected_next  = '0;
      taken_next     = '0;
      min_class_next = '0;
      cmd.cp         = {13'd0, byte_value};
      if (byte_value == 8'h00) begin
        cmd.tail = TAIL_END;
        cmd.cp   = '0;
      end else if (byte_value[7] == 1'b0) begin
        cmd.tail = TAIL_CHAR;
      end else if (byte_value[7:5] == 3'b110) begin
        acc_next       = {16'd0, byte_value[4:0]};
        expected_next  = 3'd2;
        taken_next     = 3'd1;
        min_class_next = CLASS_2B;
      end else if (byte_value[7:4] == 4'b1110) begin
        acc_next       = {17'd0, byte_value[3:0]};
        expected_next  = 3'd3;
        taken_next     = 3'd1;
        min_class_next = CLASS_3B;
      end else if (byte_value[7:3] == 5'b11110) begin
        acc_next       = {18'd0, byte_value[2:0]};
        expected_next  = 3'd4;
        taken_next     = 3'd1;
        min_class_next = CLASS_4B;
      end else begin
        cmd.rep_cnt = cmd.rep_cnt + 3'd1;
      end
    end
  end

  assign push = accept && ((cmd.rep_cnt != '0) || (cmd.tail != TAIL_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      expected  <= '0;
      taken     <= '0;
      min_class <= '0;
    end else if (accept) begin
      acc       <= acc_next;
      expected  <= expected_next;
      taken     <= taken_next;
      min_class <= min_class_next;
    end
  end

endmodule

@@ rtl/utf8d_queue.sv @@
module utf8d_queue
  import utf8d_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/utf8d_back.sv @@
`include "utf8_decoder_with_replacement_defines.svh"

module utf8d_back
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            head,
  input  logic            empty,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_stall,
  output logic [CP_W-1:0] code_point,
  output logic            replaced,
  output logic            string_end,
  output logic            last
);

  logic [REP_CNT_W-1:0] sent;
  logic                 load;
  logic                 gen;
  logic                 in_reps;
  logic [CP_W-1:0]      cp_next;
  logic                 replaced_next;
  logic                 string_end_next;
  logic                 last_next;

  assign load    = !result_valid || !result_stall;
  assign gen     = load && !empty;
  assign in_reps = (sent < head.rep_cnt);

  always_comb begin
    if (in_reps) begin
      cp_next         = REPL_CHAR;
      replaced_next   = 1'b1;
      string_end_next = 1'b0;
      last_next       = ((sent + 1'b1) == head.rep_cnt) && (head.tail == TAIL_NONE);
    end else begin
      cp_next         = (head.tail == TAIL_CHAR) ? head.cp : '0;
      replaced_next   = 1'b0;
      string_end_next = (head.tail == TAIL_END);
      last_next       = 1'b1;
    end
  end

  assign pop = gen && last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sent         <= '0;
    end else begin
      if (load) begin
        result_valid <= !empty;
      end
      if (gen) begin
        sent <= last_next ? '0 : sent + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      code_point <= cp_next;
      replaced   <= replaced_next;
      string_end <= string_end_next;
      last       <= last_next;
    end
  end

  `UTF8D_ASSERT_NOW(a_end_marker_shape, clk, rst, result_valid && string_end,
    last && !replaced && (code_point == '0), "end marker must be a clean final beat")
  `UTF8D_ASSERT_NOW(a_repl_is_qmark, clk, rst, result_valid && replaced,
    (code_point == REPL_CHAR) && !string_end, "replacement beat must carry '?'")
  `UTF8D_ASSERT_NOW(a_sent_in_range, clk, rst, !empty && (sent != '0),
    sent <= head.rep_cnt, "replacement counter ran past the run length")
  `UTF8D_ASSERT_NEXT(a_pop_ends_item, clk, rst, pop,
    result_valid && last, "popped entry must finish with a final beat")

endmodule

@@ rtl/utf8_decoder_with_replacement.sv @@
// UTF-8 decoder with '?' replacement.
// Input channel: one raw byte per beat on byte_value, byte_valid / byte_stall.
// Output channel: one code point per beat on code_point with replaced,
// string_end and last, under result_valid / result_stall.
// A byte that only opens or extends a sequence gives no beat; any other byte
// gives one to four beats, last marking the final one for that byte.
// A byte's command enters the command queue when the byte is accepted, and its
// first beat is then loaded from the queue into the output register.
// Throughput, while result_stall is low: one byte per cycle while each byte
// gives at most one beat; a run of replacements sends one beat per cycle,
// set by the single output register; the command queue (QUEUE_DEPTH entries)
// absorbs the difference. byte_stall rises only when the command queue is full.
// A stalled receiver holds the output beat; the queue keeps filling until
// full, then input stalls. No beat is lost or repeated.
// Reset (rst, synchronous) drops any pending sequence, empties the queue and
// clears result_valid; the block takes a byte in the first cycle after.
module utf8_decoder_with_replacement
  import utf8d_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  input  logic [7:0]      byte_value,
  output logic            byte_stall,
  output logic            result_valid,
  input  logic            result_stall,
  output logic [CP_W-1:0] code_point,
  output logic            replaced,
  output logic            string_end,
  output logic            last
);

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  cmd_t head;
  logic q_empty;
  logic pop;

  // Classify each byte and keep the sequence state; emit one command per byte
  // that gives output.
  utf8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_value (byte_value),
    .byte_stall (byte_stall),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Hold commands while the back end spells out replacement runs.
  utf8d_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // Expand each command into beats through the output register, one per unstalled cycle.
  utf8d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .code_point   (code_point),
    .replaced     (replaced),
    .string_end   (string_end),
    .last         (last)
  );

endmodule
